// ----- hdl/ftrb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ftrb_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int CHANNELS_DEF   = 2;

  localparam int LEN_W  = 9;
  localparam int BYTE_W = 8;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_POP   = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_LENGTH = 2'd1;
  localparam logic [1:0] ST_NO_SPACE   = 2'd2;
  localparam logic [1:0] ST_NOT_OPEN   = 2'd3;

  localparam logic [BYTE_W-1:0] LF_BYTE = 8'h0A;
  localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              channel;
    logic [LEN_W-1:0]  msg_length;
    logic              framed;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        accepted_count;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_valid;
  } out_item_t;

  // one write port per ring bank
  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] data;
  } bank_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rd_req_t;

endpackage
`default_nettype wire

// ----- hdl/ftrb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ftrb_ram #(
  parameter int RING_DEPTH = ftrb_pkg::RING_DEPTH_DEF,
  parameter int CHANNELS   = ftrb_pkg::CHANNELS_DEF,
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int PTR_W     = $clog2(RING_DEPTH),
  localparam int RAM_AW    = CH_W + PTR_W - 1
) (
  input  wire logic                          clk,
  input  wire ftrb_pkg::bank_wr_t [1:0]      wr,
  input  wire logic [1:0][RAM_AW-1:0]        wr_addr,
  input  wire ftrb_pkg::rd_req_t             rd,
  input  wire logic [RAM_AW-1:0]             rd_addr,
  output logic [ftrb_pkg::BYTE_W-1:0]        rd_data
);

  localparam int BANK_DEPTH = CHANNELS * RING_DEPTH / 2;

  // even ring positions in bank 0, odd in bank 1
  logic [ftrb_pkg::BYTE_W-1:0] bank0 [BANK_DEPTH];
  logic [ftrb_pkg::BYTE_W-1:0] bank1 [BANK_DEPTH];
  logic [ftrb_pkg::BYTE_W-1:0] q0_r;
  logic [ftrb_pkg::BYTE_W-1:0] q1_r;
  logic                        sel_r;

  always_ff @(posedge clk) begin
    if (wr[0].en) begin
      bank0[wr_addr[0]] <= wr[0].data;
    end
    if (rd.en) begin
      q0_r <= bank0[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr[1].en) begin
      bank1[wr_addr[1]] <= wr[1].data;
    end
    if (rd.en) begin
      q1_r  <= bank1[rd_addr];
      sel_r <= rd.bank;
    end
  end

  assign rd_data = sel_r ? q1_r : q0_r;

endmodule
`default_nettype wire

// ----- hdl/ftrb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ftrb_ctrl #(
  parameter int RING_DEPTH = ftrb_pkg::RING_DEPTH_DEF,
  parameter int CHANNELS   = ftrb_pkg::CHANNELS_DEF,
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int PTR_W     = $clog2(RING_DEPTH),
  localparam int RAM_AW    = CH_W + PTR_W - 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     item_vld,
  input  wire ftrb_pkg::in_item_t       item,
  output ftrb_pkg::out_item_t           result,
  output ftrb_pkg::bank_wr_t [1:0]      wr,
  output logic [1:0][RAM_AW-1:0]        wr_addr,
  output ftrb_pkg::rd_req_t             rd,
  output logic [RAM_AW-1:0]             rd_addr
);

  localparam int MASK   = RING_DEPTH - 1;
  localparam int CMP_W  = ((PTR_W > ftrb_pkg::LEN_W) ? PTR_W : ftrb_pkg::LEN_W) + 2;

  typedef logic [PTR_W-1:0]           ptr_t;
  typedef logic [ftrb_pkg::LEN_W-1:0] len_t;

  ptr_t put_r   [CHANNELS];
  ptr_t put_nxt [CHANNELS];
  ptr_t get_r   [CHANNELS];
  ptr_t get_nxt [CHANNELS];
  ptr_t wi_r    [CHANNELS];
  ptr_t wi_nxt  [CHANNELS];
  len_t left_r  [CHANNELS];
  len_t left_nxt[CHANNELS];
  logic [CHANNELS-1:0] open_r;
  logic [CHANNELS-1:0] open_nxt;
  logic [CHANNELS-1:0] frm_r;
  logic [CHANNELS-1:0] frm_nxt;

  logic                        ch_ok;
  logic [CH_W-1:0]             ch;
  ptr_t                        put;
  ptr_t                        get;
  ptr_t                        wi;
  ptr_t                        occ;
  ptr_t                        a0;
  ptr_t                        a1;
  logic                        en0;
  logic                        en1;
  logic [ftrb_pkg::BYTE_W-1:0] d0;
  logic [CMP_W-1:0]            len_c;
  logic [CMP_W-1:0]            limit_c;
  logic [CMP_W-1:0]            need_c;

  assign ch_ok = 32'(item.channel) < 32'(CHANNELS);
  assign ch    = CH_W'(item.channel);
  assign put   = put_r[ch];
  assign get   = get_r[ch];
  assign wi    = wi_r[ch];
  assign occ   = put - get;

  assign len_c   = CMP_W'(item.msg_length);
  assign limit_c = item.framed ? CMP_W'(MASK - 2) : CMP_W'(MASK);
  assign need_c  = len_c + (item.framed ? CMP_W'(2) : CMP_W'(0)) + CMP_W'(occ);

  always_comb begin
    put_nxt  = put_r;
    get_nxt  = get_r;
    wi_nxt   = wi_r;
    left_nxt = left_r;
    open_nxt = open_r;
    frm_nxt  = frm_r;
    result   = '0;
    en0      = 1'b0;
    en1      = 1'b0;
    a0       = wi;
    d0       = item.data_byte;
    rd       = '0;
    rd_addr  = {ch, get[PTR_W-1:1]};
    rd.bank  = get[0];
    if (item_vld) begin
      if (!ch_ok) begin
        result.status = ftrb_pkg::ST_NOT_OPEN;
      end else begin
        unique case (item.cmd)
          ftrb_pkg::CMD_BEGIN: begin
            open_nxt[ch] = 1'b0;
            if (len_c == '0 || len_c > limit_c) begin
              result.status = ftrb_pkg::ST_BAD_LENGTH;
            end else if (need_c >= CMP_W'(MASK)) begin
              result.status = ftrb_pkg::ST_NO_SPACE;
            end else begin
              wi_nxt[ch]            = put + ptr_t'(item.framed);
              left_nxt[ch]          = item.msg_length;
              frm_nxt[ch]           = item.framed;
              open_nxt[ch]          = 1'b1;
              en0                   = item.framed;
              a0                    = put;
              d0                    = ftrb_pkg::LF_BYTE;
              result.accepted_count = item.msg_length[7:0];
            end
          end
          ftrb_pkg::CMD_DATA: begin
            if (!open_r[ch] || left_r[ch] == '0) begin
              result.status = ftrb_pkg::ST_NOT_OPEN;
            end else begin
              en0          = 1'b1;
              left_nxt[ch] = left_r[ch] - len_t'(1);
              wi_nxt[ch]   = wi + ptr_t'(1);
              if (left_r[ch] == len_t'(1)) begin
                // close the message: append CR if framed, then commit put
                en1          = frm_r[ch];
                wi_nxt[ch]   = wi + (frm_r[ch] ? ptr_t'(2) : ptr_t'(1));
                put_nxt[ch]  = wi + (frm_r[ch] ? ptr_t'(2) : ptr_t'(1));
                open_nxt[ch] = 1'b0;
              end
            end
          end
          ftrb_pkg::CMD_POP: begin
            if (get != put) begin
              rd.en           = 1'b1;
              result.tx_valid = 1'b1;
              get_nxt[ch]     = get + ptr_t'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // consecutive ring positions fall in opposite banks
  assign a1 = a0 + ptr_t'(1);

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      if (a0[0] == 1'(b)) begin
        wr[b].en   = en0;
        wr[b].data = d0;
        wr_addr[b] = {ch, a0[PTR_W-1:1]};
      end else begin
        wr[b].en   = en1;
        wr[b].data = ftrb_pkg::CR_BYTE;
        wr_addr[b] = {ch, a1[PTR_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        put_r[c]  <= '0;
        get_r[c]  <= '0;
        wi_r[c]   <= '0;
        left_r[c] <= '0;
      end
      open_r <= '0;
      frm_r  <= '0;
    end else begin
      put_r  <= put_nxt;
      get_r  <= get_nxt;
      wi_r   <= wi_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
      frm_r  <= frm_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/framed_tx_ring_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                      Handshake
// input     start, busy, in_item       taken when start && !busy
// result    out_valid, out_item        one-cycle strobe, one result per item
//
// An item enters every cycle; its result strobes after the input register, then
// the index/admission logic and ring bank read, both registered at the output.
// busy never rises: each item settles its channel's indexes without a stall and
// the ring is split into even/odd banks so LF/CR framing writes fit the cycle.
// Reset clears indexes and message flags at once; ring contents are not cleared.
// The receiver cannot stall, so results leave as they are made.
module framed_tx_ring_buffer #(
  parameter int RING_DEPTH = ftrb_pkg::RING_DEPTH_DEF,
  parameter int CHANNELS   = ftrb_pkg::CHANNELS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire ftrb_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output ftrb_pkg::out_item_t      out_item
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int RAM_AW = CH_W + PTR_W - 1;

  ftrb_pkg::in_item_t          item_r;
  logic                        item_vld_r;
  ftrb_pkg::out_item_t         res_nxt;
  ftrb_pkg::out_item_t         res_r;
  logic                        out_valid_r;
  ftrb_pkg::bank_wr_t [1:0]    wr;
  logic [1:0][RAM_AW-1:0]      wr_addr;
  ftrb_pkg::rd_req_t           rd;
  logic [RAM_AW-1:0]           rd_addr;
  logic [ftrb_pkg::BYTE_W-1:0] rd_data;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      item_vld_r  <= start && !busy;
      out_valid_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= in_item;
    res_r  <= res_nxt;
  end

  ftrb_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .CHANNELS   (CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld_r),
    .item     (item_r),
    .result   (res_nxt),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .rd       (rd),
    .rd_addr  (rd_addr)
  );

  ftrb_ram #(
    .RING_DEPTH (RING_DEPTH),
    .CHANNELS   (CHANNELS)
  ) u_ram (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .rd      (rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    out_item         = res_r;
    out_item.tx_byte = res_r.tx_valid ? rd_data : '0;
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- hdl/ftrb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ftrb_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire ftrb_pkg::out_item_t out_item
);

  // every taken item strobes its result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("ftrb: taken item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("ftrb: result without a taken item");

  a_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.tx_valid) |->
      (out_item.status == ftrb_pkg::ST_OK && out_item.accepted_count == '0))
    else $error("ftrb: drained byte with non-ok status or count");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ftrb_pkg::ST_OK) |->
      (out_item.accepted_count == '0 && !out_item.tx_valid && out_item.tx_byte == '0))
    else $error("ftrb: rejected item carries payload");

endmodule

bind framed_tx_ring_buffer ftrb_checker u_ftrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
